// ===== rtl/tccs_pkg.sv =====
// shared types and constants for the text console cursor/scroll block
// no dependencies; imported by every module of the block

package tccs_pkg;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int POS_W      = 11;
    localparam int STORE_AW   = 12;
    localparam int TDATA_W    = 48;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'hF0;

    // result fields, last field in the lowest bits
    typedef struct packed {
        logic                  did_scroll;
        logic [ROW_W-1:0]      scroll_base;
        logic [POS_W-1:0]      cursor_position;
        logic [15:0]           cell_value;
        logic [COL_W-1:0]      cell_col;
        logic [ROW_W-1:0]      cell_row;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // classified item handed from front to back
    typedef struct packed {
        res_t                  res;
        logic                  written;
        logic [STORE_AW-1:0]   wr_addr;
        logic [STORE_AW-1:0]   clr_addr;
        logic [7:0]            attr;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_HOLD
    } back_state_t;

endpackage

// ===== rtl/tccs_front.sv =====
// front end: accepts character codes, tracks cursor and ring base, builds commands
// depends on tccs_pkg

module tccs_front import tccs_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        init_busy,
    input  logic        q_ready,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam logic [ROW_W-1:0]   ROWS_M1  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]     ROWS_EXT = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]     COLS_EXT = (COL_W + 1)'(COLUMNS);
    localparam logic [STORE_AW-1:0] COLS_AW = STORE_AW'(COLUMNS);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] base_reg, base_next;
    logic [7:0]       attr_reg;

    logic             accept;
    logic             is_nl;
    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic             at_last;
    logic             scroll;
    logic [ROW_W:0]   prow_sum;
    logic [ROW_W-1:0] prow;
    logic [STORE_AW-1:0] pos_full;

    assign s_tready = q_ready && !init_busy;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        is_nl   = (s_tdata == NEWLINE_CODE);
        col_inc = {1'b0, col_reg} + 1'b1;
        wrap    = is_nl || (col_inc >= COLS_EXT);
        at_last = (row_reg >= ROWS_M1);
        scroll  = wrap && at_last;

        col_next = wrap ? '0 : col_inc[COL_W-1:0];
        if (!wrap) begin
            row_next = row_reg;
        end else if (at_last) begin
            row_next = ROWS_M1;
        end else begin
            row_next = row_reg + 1'b1;
        end

        if (!scroll) begin
            base_next = base_reg;
        end else if (base_reg == ROWS_M1) begin
            base_next = '0;
        end else begin
            base_next = base_reg + 1'b1;
        end

        // visible row to store row through the ring base
        prow_sum = {1'b0, row_reg} + {1'b0, base_reg};
        if (prow_sum >= ROWS_EXT) begin
            prow_sum = prow_sum - ROWS_EXT;
        end
        prow = prow_sum[ROW_W-1:0];

        pos_full = STORE_AW'(row_next) * COLS_AW + STORE_AW'(col_next);

        q_cmd.written                 = !is_nl;
        q_cmd.res.cell_row            = is_nl ? '0 : row_reg;
        q_cmd.res.cell_col            = is_nl ? '0 : col_reg;
        q_cmd.res.cell_value          = is_nl ? 16'd0 : {attr_reg, s_tdata};
        q_cmd.res.cursor_position     = pos_full[POS_W-1:0];
        q_cmd.res.scroll_base         = base_next;
        q_cmd.res.did_scroll          = scroll;
        q_cmd.wr_addr  = STORE_AW'(prow) * COLS_AW + STORE_AW'(col_reg);
        // the new bottom row sits where the old ring base was
        q_cmd.clr_addr = STORE_AW'(base_reg) * COLS_AW;
        q_cmd.attr     = attr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            attr_reg <= ATTR_RESET;
        end else begin
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                base_reg <= base_next;
            end
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/tccs_queue.sv =====
// two-entry command queue between front end and back end
// depends on tccs_pkg for the command type

module tccs_queue import tccs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    output logic valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tccs_back.sv =====
// back end: writes the screen store, clears rows on scroll, drives the result register
// depends on tccs_pkg

module tccs_back import tccs_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                init_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tuser
);

    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]    LAST_CELL = AW'(DEPTH - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

    logic [15:0] store_mem [DEPTH];

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [AW-1:0]    init_cnt_reg;
    logic [COL_W-1:0] clr_cnt_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    logic        out_user_reg;

    logic        out_free;
    logic        load_q, load_hold;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;
    logic [STORE_AW-1:0] clr_sum;

    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(TDATA_W - RES_W)'(0), out_res_reg};
    assign m_tuser   = out_user_reg;
    assign init_busy = (state_reg == BK_INIT);
    assign clr_sum   = cmd_reg.clr_addr + STORE_AW'(clr_cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_INIT: begin
                if (init_cnt_reg == LAST_CELL) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (q_valid && out_free && q_cmd.res.did_scroll) state_next = BK_CLEAR;
            end
            BK_CLEAR: begin
                if (clr_cnt_reg == LAST_COL) state_next = BK_HOLD;
            end
            BK_HOLD: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_INIT;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        load_q    = 1'b0;
        load_hold = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = {ATTR_RESET, SPACE_CODE};
        case (state_reg)
            BK_INIT: begin
                mem_we   = 1'b1;
                mem_addr = init_cnt_reg;
            end
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop     = 1'b1;
                    load_q    = !q_cmd.res.did_scroll;
                    mem_we    = q_cmd.written;
                    mem_addr  = q_cmd.wr_addr[AW-1:0];
                    mem_wdata = q_cmd.res.cell_value;
                end
            end
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_sum[AW-1:0];
                mem_wdata = {cmd_reg.attr, SPACE_CODE};
            end
            BK_HOLD: begin
                load_hold = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (load_q) begin
            out_res_reg  <= q_cmd.res;
            out_user_reg <= q_cmd.written;
        end else if (load_hold) begin
            out_res_reg  <= cmd_reg.res;
            out_user_reg <= cmd_reg.written;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_INIT;
            init_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_INIT) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (state_reg == BK_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end else begin
                clr_cnt_reg <= '0;
            end
            if (load_q || load_hold) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/text_console_cursor_scroll_top.sv =====
// top level of the text console: front end, command queue and back end
// depends on tccs_pkg, tccs_front, tccs_queue, tccs_back
//
// usage:
//   s_ channel carries one character code per transaction; code 10 is a
//   newline, every other code is written at the cursor in the current
//   attribute. m_ channel returns one result per character: m_tuser flags a
//   written cell, m_tdata holds cell position, value, new cursor and ring base.
//   cfg_we / cfg_wdata set the colour attribute; write it only when idle.
// flow:
//   a plain character or a newline without scroll passes through a queue
//   slot and the result register; one item per cycle can be sustained while
//   m_tready is high and no scroll runs. a scroll keeps the back end busy
//   clearing the bottom row through the single store write port, then holding the result.
// reset:
//   aresetn (synchronous, active low) resets cursor and ring base to zero and
//   the attribute to 0xF0, then the store is filled with spaces, COLUMNS*ROWS
//   cells (2000 at the default size), with s_tready low.
// stalls:
//   a result is held on m_ while m_tready is low; the two-entry queue keeps
//   accepting until full, then s_tready drops.

module text_console_cursor_scroll_top import tccs_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_code
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] cell_row, [11:5] cell_col, [27:12] cell_value,
    // [38:28] cursor_position, [43:39] scroll_base, [44] did_scroll
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tuser,   // [0] cell_written
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata  // text_attribute
);

    logic init_busy;
    logic q_ready, q_push, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .init_busy (init_busy),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    tccs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd)
    );

    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/tccs_checker.sv =====
// port-level checks for the text console top level, with the bind that attaches them
// depends on tccs_pkg

module tccs_checker import tccs_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [TDATA_W-1:0]  m_tdata,
    input logic                m_tuser
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a reset cycle leaves the output empty and input held off for the store fill
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity right after reset");

    // a newline result carries no cell
    a_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[27:0] == 28'd0)
        else $error("newline result with cell fields");

    // pad bits above the result fields stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:RES_W] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps
// testbench for text_console_cursor_scroll_top: streams character codes, predicts the
// written cell, cursor and ring base of every transaction and checks them on the m_ side
// depends on tccs_pkg and the rtl of the block

module tb_text_console_cursor_scroll_top;
    import tccs_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int RESET_CYCLES   = 8;
    // a scroll clears a whole row before its result appears
    localparam int DRAIN_CYCLES   = COLUMNS + 16;
    // reset clear pass covers every store cell with nothing accepted
    localparam int WATCHDOG_LIMIT = 10 * COLUMNS * ROWS;

    typedef struct {
        res_t res;
        logic written;
    } console_result_t;

    class console_scoreboard;
        logic [7:0]      attribute;
        int unsigned     col;
        int unsigned     row;
        int unsigned     base;
        console_result_t pending[$];
        int              errors;
        int              chars;
        int              results;
        int              scrolls;
        int              wraps;

        function new();
            attribute = ATTR_RESET;
            col       = 0;
            row       = 0;
            base      = 0;
            errors    = 0;
            chars     = 0;
            results   = 0;
            scrolls   = 0;
            wraps     = 0;
        endfunction

        function bit advance_row();
            if (row >= ROWS - 1) begin
                row  = ROWS - 1;
                base = (base + 1) % ROWS;
                scrolls++;
                return 1'b1;
            end
            row++;
            return 1'b0;
        endfunction

        function void note_char(logic [7:0] code);
            console_result_t exp;
            exp.written = 1'b0;
            exp.res     = '0;
            chars++;
            if (code == NEWLINE_CODE) begin
                col = 0;
                exp.res.did_scroll = advance_row();
            end else begin
                exp.written        = 1'b1;
                exp.res.cell_row   = ROW_W'(row);
                exp.res.cell_col   = COL_W'(col);
                exp.res.cell_value = {attribute, code};
                col++;
                if (col >= COLUMNS) begin
                    col = 0;
                    wraps++;
                    exp.res.did_scroll = advance_row();
                end
            end
            exp.res.cursor_position = POS_W'(col + row * COLUMNS);
            exp.res.scroll_base     = ROW_W'(base);
            pending.push_back(exp);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] data, logic user);
            console_result_t exp;
            res_t            got;
            got = data[RES_W-1:0];
            results++;
            if (pending.size() == 0) begin
                $error("result with no character pending: tdata %h tuser %b", data, user);
                errors++;
                return;
            end
            exp = pending.pop_front();
            compare_field("cell_written", exp.written, user);
            compare_field("cell_row", exp.res.cell_row, got.cell_row);
            compare_field("cell_col", exp.res.cell_col, got.cell_col);
            compare_field("cell_value", exp.res.cell_value, got.cell_value);
            compare_field("cursor_position", exp.res.cursor_position, got.cursor_position);
            compare_field("scroll_base", exp.res.scroll_base, got.scroll_base);
            compare_field("did_scroll", exp.res.did_scroll, got.did_scroll);
            compare_field("tdata padding", 0, data[TDATA_W-1:RES_W]);
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;
    logic               m_tvalid;
    logic               m_tready  = 1'b1;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = 8'h00;

    console_scoreboard  sb = new();
    bit                 idle_on = 1'b1;
    int                 settings = 0;
    int                 quiet_cycles = 0;

    always #6 aclk = ~aclk;

    text_console_cursor_scroll_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    task automatic send_char(input logic [7:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(code);
    endtask

    task automatic release_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // attribute only changes once every result is out and a clear has had time to end
    task automatic set_attribute(input logic [7:0] value);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.attribute = value;
        settings++;
    endtask

    task automatic type_text(input int count, input int newline_odds);
        logic [7:0] code;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, newline_odds - 1) == 0)
                code = NEWLINE_CODE;
            else
                code = 8'($urandom_range(0, 255));
            send_char(code);
        end
        release_stream();
    endtask

    // receiver stalls in bursts
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[text_console_cursor_scroll_top] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        // store clear pass holds s_tready low
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        // extremes of the code, then newlines down to the last row and one scroll
        send_char(8'h00);
        send_char(8'hFF);
        repeat (ROWS) send_char(NEWLINE_CODE);
        send_char(8'h0B);
        send_char(8'h7F);
        release_stream();

        set_attribute(8'h00);
        type_text(200, 8);
        // long lines: row wraps and wrap-driven scrolls
        set_attribute(8'hFF);
        type_text(200, 64);
        // newline heavy: back-to-back scrolls
        set_attribute(8'($urandom_range(0, 255)));
        type_text(150, 2);
        set_attribute(8'($urandom_range(0, 255)));
        type_text(200, 10);
        idle_on = 1'b0;
        set_attribute(8'hA5);
        type_text(150, 8);

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d characters under %0d attribute writes: %0d row wraps, %0d scrolls",
                 sb.chars, settings, sb.wraps, sb.scrolls);
        $display("%0d results compared, %0d mismatches", sb.results, sb.errors);
        if (sb.errors == 0)
            $display("[text_console_cursor_scroll_top] OK");
        else
            $display("[text_console_cursor_scroll_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tccs_pkg.sv
rtl/tccs_front.sv
rtl/tccs_queue.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll_top.sv
rtl/tccs_checker.sv
tb/tb_text_console_cursor_scroll_top.sv
